// File: design/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ffha_pkg.sv
package ffha_pkg;

    // Field widths.
    localparam int AW  = 21;
    localparam int OPW = 2;
    localparam int STW = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    // Heap geometry.
    localparam int SEGMENTS_DEF    = 64;
    localparam int HEAP_MAX_BYTES  = 1048576;
    localparam int INIT_BYTES      = 524288;
    localparam int PAGE_BYTES      = 4096;
    localparam int HEADER_BYTES    = 48;
    localparam int ROUND_MASK      = 15;
    localparam int MIN_SPLIT_BYTES = 16;
    localparam int INIT_PAGES      = (INIT_BYTES / PAGE_BYTES == 0) ? 1
                                     : INIT_BYTES / PAGE_BYTES;
    localparam int INIT_HEAP_BYTES = INIT_PAGES * PAGE_BYTES;

    // Width of the spare-entry search groups.
    localparam int SPARE_GROUP = 8;

    // Operation codes; the last one leaves the heap unchanged and returns an ok status.
    localparam logic [OPW-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPW-1:0] OP_FREE  = 2'd1;
    localparam logic [OPW-1:0] OP_GROW  = 2'd2;
    localparam logic [OPW-1:0] OP_NONE  = 2'd3;

    // Status codes.
    localparam logic [STW-1:0] ST_OK       = 2'd0;
    localparam logic [STW-1:0] ST_ZERO     = 2'd1;
    localparam logic [STW-1:0] ST_NO_SPACE = 2'd2;
    localparam logic [STW-1:0] ST_BAD_FREE = 2'd3;

    // Live-bit update request from the sequencer.
    typedef struct packed {
        logic set_en;
        logic clr_en;
    } live_ctl_t;

endpackage

// File: design/ffha_table.sv
`include "assert_macros.svh"

module ffha_table
    import ffha_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF,
    localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1,
    localparam int LW = $clog2(SEGMENTS + 1),
    localparam int EW = 2 * AW + 1 + LW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [IW-1:0] rd_addr,
    output logic [EW-1:0] rd_a,
    output logic [LW-1:0] rd_b,
    input  logic          wa_en,
    input  logic [IW-1:0] wa_addr,
    input  logic [EW-1:0] wa_data,
    input  logic          wb_en,
    input  logic [IW-1:0] wb_addr,
    input  logic [LW-1:0] wb_data
);

    localparam logic [LW-1:0] NIL = LW'(SEGMENTS);
    localparam logic [EW-1:0] HEAD_RESET =
        {{AW{1'b0}}, AW'(INIT_HEAP_BYTES - HEADER_BYTES), 1'b1, NIL};

    logic [EW-1:0] mem_a [SEGMENTS];
    logic [LW-1:0] mem_b [SEGMENTS];
    logic [EW-1:0] a_q;
    logic [LW-1:0] b_q;
    logic          a0_written_reg;
    logic          b0_written_reg;
    logic          a0_sel_reg;
    logic          b0_sel_reg;

    // Segment words: start, size, free flag and forward link; back links apart.
    always_ff @(posedge clk)
    begin
        if (wa_en)
        begin
            mem_a[wa_addr] <= wa_data;
        end
        if (wb_en)
        begin
            mem_b[wb_addr] <= wb_data;
        end
        a_q <= mem_a[rd_addr];
        b_q <= mem_b[rd_addr];
    end

    // The head entry reads as its reset value until it is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_written_reg <= 1'b0;
            b0_written_reg <= 1'b0;
            a0_sel_reg     <= 1'b0;
            b0_sel_reg     <= 1'b0;
        end
        else
        begin
            if (wa_en && wa_addr == '0)
            begin
                a0_written_reg <= 1'b1;
            end
            if (wb_en && wb_addr == '0)
            begin
                b0_written_reg <= 1'b1;
            end
            a0_sel_reg <= (rd_addr == '0) && !a0_written_reg;
            b0_sel_reg <= (rd_addr == '0) && !b0_written_reg;
        end
    end

    assign rd_a = a0_sel_reg ? HEAD_RESET : a_q;
    assign rd_b = b0_sel_reg ? NIL : b_q;

endmodule

// File: design/ffha_spare.sv
`include "assert_macros.svh"

module ffha_spare
    import ffha_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF,
    localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1,
    localparam int NG = (SEGMENTS + SPARE_GROUP - 1) / SPARE_GROUP,
    localparam int GIW = $clog2(SPARE_GROUP)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  live_ctl_t     ctl,
    input  logic [IW-1:0] set_idx,
    input  logic [IW-1:0] clr_idx,
    output logic          spare_found,
    output logic [IW-1:0] spare_idx
);

    logic [SEGMENTS-1:0] live_reg;
    logic [SEGMENTS-1:0] live_next;
    logic [NG-1:0]       grp_any_reg;
    logic [NG-1:0]       grp_any_next;
    logic [GIW-1:0]      grp_idx_reg  [NG];
    logic [GIW-1:0]      grp_idx_next [NG];

    // Live bits: the head entry is always in use.
    always_comb
    begin
        live_next = live_reg;
        if (ctl.set_en)
        begin
            live_next[set_idx] = 1'b1;
        end
        if (ctl.clr_en)
        begin
            live_next[clr_idx] = 1'b0;
        end
    end

    // First tier of the search: lowest unused entry inside each group.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = SPARE_GROUP - 1; b >= 0; b--)
            begin
                if (g * SPARE_GROUP + b < SEGMENTS)
                begin
                    if (!live_reg[g * SPARE_GROUP + b])
                    begin
                        grp_any_next[g] = 1'b1;
                        grp_idx_next[g] = GIW'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= SEGMENTS'(1);
            grp_any_reg <= '0;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= '0;
            end
        end
        else
        begin
            live_reg    <= live_next;
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    // Second tier: lowest group that has an unused entry.
    always_comb
    begin
        spare_found = 1'b0;
        spare_idx   = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                spare_found = 1'b1;
                spare_idx   = IW'(g * SPARE_GROUP + int'(grp_idx_reg[g]));
            end
        end
    end

    `FFHA_ASSERT_ALWAYS(a_head_live, live_reg[0], "head segment entry lost its live bit")

endmodule

// File: design/first_fit_heap_allocator.sv
// A word is taken in S_IDLE and goes to S_WALK, or straight to S_OUT when it needs no walk;
// S_WALK follows the chain through the single read port of the segment table, one entry
// per cycle and at most SEGMENTS entries, then S_SPLIT, S_FNEXT and S_FPREV, or S_APPEND
// rewrite entries where needed; S_OUT loads the result register once the previous result is taken.
// One word at a time: a new word is taken only once the last one has left S_OUT.
// Reset (rst_n low, asynchronous) leaves one free segment over the initial heap;
// no clearing pass is needed, so a word is accepted in the first cycle after reset.
`include "assert_macros.svh"

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int SEGMENTS = SEGMENTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // operation[1:0], request_bytes[22:2], block_offset[43:23], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // payload_offset[20:0], status[22:21], total_bytes[43:23], used_bytes[64:44], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int LW = $clog2(SEGMENTS + 1);
    localparam int EW = 2 * AW + 1 + LW;
    localparam int NW = AW + 1;
    localparam int SW = AW + 2;
    localparam int HW = AW + 3;
    localparam logic [LW-1:0] NIL = LW'(SEGMENTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WALK   = 4'd1;
    localparam logic [3:0] S_SPLIT  = 4'd2;
    localparam logic [3:0] S_FNEXT  = 4'd3;
    localparam logic [3:0] S_FPREV  = 4'd4;
    localparam logic [3:0] S_APPEND = 4'd5;
    localparam logic [3:0] S_OUT    = 4'd6;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] size;
        logic          free;
        logic [LW-1:0] after;
    } seg_t;

    logic [3:0]     state_reg,   state_next;
    logic [OPW-1:0] op_reg,      op_next;
    logic [NW-1:0]  need_reg,    need_next;
    logic [AW-1:0]  off_reg,     off_next;
    logic [SW-1:0]  add_reg,     add_next;
    logic [IW-1:0]  cur_reg,     cur_next;
    logic [IW-1:0]  steps_reg,   steps_next;
    logic [IW-1:0]  spare_reg,   spare_next;
    seg_t           ent_reg,     ent_next;
    logic [LW-1:0]  bef_reg,     bef_next;
    logic [AW-1:0]  heap_top_reg, heap_top_next;
    logic [AW-1:0]  alloc_reg,   alloc_next;
    logic [AW-1:0]  res_pay_reg, res_pay_next;
    logic [STW-1:0] res_st_reg,  res_st_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [AW-1:0]  out_pay_reg, out_pay_next;
    logic [STW-1:0] out_st_reg,  out_st_next;
    logic [AW-1:0]  out_tot_reg, out_tot_next;
    logic [AW-1:0]  out_used_reg, out_used_next;

    logic [IW-1:0]  rd_addr;
    logic [EW-1:0]  rd_a_vec;
    seg_t           rd_a;
    logic [LW-1:0]  rd_b;
    logic           wa_en;
    logic [IW-1:0]  wa_addr;
    seg_t           wa_data;
    logic           wb_en;
    logic [IW-1:0]  wb_addr;
    logic [LW-1:0]  wb_data;
    live_ctl_t      live_ctl;
    logic [IW-1:0]  set_idx;
    logic [IW-1:0]  clr_idx;
    logic           spare_found;
    logic [IW-1:0]  spare_idx;

    logic [OPW-1:0] in_op;
    logic [AW-1:0]  in_req;
    logic [AW-1:0]  in_off;
    logic [NW-1:0]  in_need;
    logic [SW-1:0]  in_add;
    logic           over_max;
    logic           accept;
    logic           end_chain;
    logic           alloc_hit;
    logic           split_big;
    logic [SW-1:0]  span;
    logic           free_hit;
    logic           pay_on_fail;

    ffha_table #(.SEGMENTS(SEGMENTS)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_a    (rd_a_vec),
        .rd_b    (rd_b),
        .wa_en   (wa_en),
        .wa_addr (wa_addr),
        .wa_data (wa_data),
        .wb_en   (wb_en),
        .wb_addr (wb_addr),
        .wb_data (wb_data)
    );

    ffha_spare #(.SEGMENTS(SEGMENTS)) u_spare (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (live_ctl),
        .set_idx     (set_idx),
        .clr_idx     (clr_idx),
        .spare_found (spare_found),
        .spare_idx   (spare_idx)
    );

    assign rd_a = rd_a_vec;

    // Input word fields and the sizes derived from them.
    assign in_op    = s_tdata[1:0];
    assign in_req   = s_tdata[22:2];
    assign in_off   = s_tdata[43:23];
    assign in_need  = ({1'b0, in_req} + NW'(ROUND_MASK)) & ~NW'(ROUND_MASK);
    assign in_add   = ({2'b00, in_req} + SW'(HEADER_BYTES + PAGE_BYTES - 1))
                      & ~SW'(PAGE_BYTES - 1);
    assign over_max = (HW'(heap_top_reg) + HW'(in_add)) > HW'(HEAP_MAX_BYTES);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Tests on the entry just read during the chain walk.
    assign end_chain = (rd_a.after == NIL) || (steps_reg == IW'(SEGMENTS - 1));
    assign alloc_hit = rd_a.free && (NW'(rd_a.size) >= need_reg);
    assign split_big = SW'(rd_a.size) > (SW'(need_reg) + SW'(HEADER_BYTES + MIN_SPLIT_BYTES));
    assign span      = (SW'(need_reg) + SW'(HEADER_BYTES + ROUND_MASK)) & ~SW'(ROUND_MASK);
    assign free_hit  = (NW'(rd_a.start) + NW'(HEADER_BYTES)) == NW'(off_reg);

    // Sequencer: walks the chain and rewrites the affected entries.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        need_next     = need_reg;
        off_next      = off_reg;
        add_next      = add_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        spare_next    = spare_reg;
        ent_next      = ent_reg;
        bef_next      = bef_reg;
        heap_top_next = heap_top_reg;
        alloc_next    = alloc_reg;
        res_pay_next  = res_pay_reg;
        res_st_next   = res_st_reg;
        rd_addr       = cur_reg;
        wa_en         = 1'b0;
        wa_addr       = cur_reg;
        wa_data       = ent_reg;
        wb_en         = 1'b0;
        wb_addr       = cur_reg;
        wb_data       = NIL;
        live_ctl      = '0;
        set_idx       = spare_reg;
        clr_idx       = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = in_op;
                    need_next    = in_need;
                    off_next     = in_off;
                    add_next     = in_add;
                    cur_next     = '0;
                    steps_next   = '0;
                    rd_addr      = '0;
                    res_pay_next = '0;
                    res_st_next  = ST_OK;
                    state_next   = S_WALK;
                    case (in_op)
                        OP_ALLOC:
                        begin
                            if (in_req == '0)
                            begin
                                res_st_next = ST_ZERO;
                                state_next  = S_OUT;
                            end
                        end
                        OP_FREE:
                        begin
                            if (in_off == '0)
                            begin
                                state_next = S_OUT;
                            end
                        end
                        OP_GROW:
                        begin
                            if (over_max)
                            begin
                                res_st_next = ST_NO_SPACE;
                                state_next  = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                ent_next = rd_a;
                bef_next = rd_b;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (alloc_hit && split_big && spare_found)
                        begin
                            // Carve the tail off into a spare entry.
                            wa_en         = 1'b1;
                            wa_addr       = spare_idx;
                            wa_data.start = rd_a.start + AW'(span);
                            wa_data.size  = rd_a.size - AW'(span);
                            wa_data.free  = 1'b1;
                            wa_data.after = rd_a.after;
                            wb_en         = 1'b1;
                            wb_addr       = spare_idx;
                            wb_data       = LW'(cur_reg);
                            live_ctl.set_en = 1'b1;
                            set_idx       = spare_idx;
                            spare_next    = spare_idx;
                            state_next    = S_SPLIT;
                        end
                        else if (alloc_hit)
                        begin
                            wa_en        = 1'b1;
                            wa_data      = rd_a;
                            wa_data.free = 1'b0;
                            alloc_next   = alloc_reg + rd_a.size;
                            res_pay_next = rd_a.start + AW'(HEADER_BYTES);
                            state_next   = S_OUT;
                        end
                        else if (end_chain)
                        begin
                            res_st_next = ST_NO_SPACE;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            rd_addr    = rd_a.after[IW-1:0];
                            cur_next   = rd_a.after[IW-1:0];
                            steps_next = steps_reg + 1'b1;
                        end
                    end
                    OP_FREE:
                    begin
                        if (free_hit)
                        begin
                            if (!rd_a.free)
                            begin
                                alloc_next = alloc_reg - rd_a.size;
                            end
                            ent_next.free = 1'b1;
                            rd_addr       = rd_a.after[IW-1:0];
                            state_next    = S_FNEXT;
                        end
                        else if (end_chain)
                        begin
                            res_st_next = ST_BAD_FREE;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            rd_addr    = rd_a.after[IW-1:0];
                            cur_next   = rd_a.after[IW-1:0];
                            steps_next = steps_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        // Grow: find the last segment, then extend or append.
                        if (end_chain)
                        begin
                            if (rd_a.free)
                            begin
                                wa_en         = 1'b1;
                                wa_data       = rd_a;
                                wa_data.size  = rd_a.size + AW'(add_reg);
                                heap_top_next = heap_top_reg + AW'(add_reg);
                                state_next    = S_OUT;
                            end
                            else if (spare_found)
                            begin
                                wa_en         = 1'b1;
                                wa_addr       = spare_idx;
                                wa_data.start = heap_top_reg;
                                wa_data.size  = AW'(add_reg) - AW'(HEADER_BYTES);
                                wa_data.free  = 1'b1;
                                wa_data.after = NIL;
                                wb_en         = 1'b1;
                                wb_addr       = spare_idx;
                                wb_data       = LW'(cur_reg);
                                live_ctl.set_en = 1'b1;
                                set_idx       = spare_idx;
                                spare_next    = spare_idx;
                                state_next    = S_APPEND;
                            end
                            else
                            begin
                                res_st_next = ST_NO_SPACE;
                                state_next  = S_OUT;
                            end
                        end
                        else
                        begin
                            rd_addr    = rd_a.after[IW-1:0];
                            cur_next   = rd_a.after[IW-1:0];
                            steps_next = steps_reg + 1'b1;
                        end
                    end
                endcase
            end

            S_SPLIT:
            begin
                // Shrink the chosen segment and point it at the new tail.
                wa_en         = 1'b1;
                wa_data.size  = AW'(span) - AW'(HEADER_BYTES);
                wa_data.free  = 1'b0;
                wa_data.after = LW'(spare_reg);
                if (ent_reg.after != NIL)
                begin
                    wb_en   = 1'b1;
                    wb_addr = ent_reg.after[IW-1:0];
                    wb_data = LW'(spare_reg);
                end
                alloc_next   = alloc_reg + (AW'(span) - AW'(HEADER_BYTES));
                res_pay_next = ent_reg.start + AW'(HEADER_BYTES);
                state_next   = S_OUT;
            end

            S_FNEXT:
            begin
                // Merge with a free right neighbour.
                if (ent_reg.after != NIL && rd_a.free)
                begin
                    ent_next.size  = ent_reg.size + rd_a.size + AW'(HEADER_BYTES);
                    ent_next.after = rd_a.after;
                    if (rd_a.after != NIL)
                    begin
                        wb_en   = 1'b1;
                        wb_addr = rd_a.after[IW-1:0];
                        wb_data = LW'(cur_reg);
                    end
                    live_ctl.clr_en = 1'b1;
                    clr_idx         = ent_reg.after[IW-1:0];
                end
                rd_addr    = bef_reg[IW-1:0];
                state_next = S_FPREV;
            end

            S_FPREV:
            begin
                // Merge into a free left neighbour, else write the segment back.
                wa_en = 1'b1;
                if (bef_reg != NIL && rd_a.free)
                begin
                    wa_addr       = bef_reg[IW-1:0];
                    wa_data       = rd_a;
                    wa_data.size  = rd_a.size + ent_reg.size + AW'(HEADER_BYTES);
                    wa_data.after = ent_reg.after;
                    if (ent_reg.after != NIL)
                    begin
                        wb_en   = 1'b1;
                        wb_addr = ent_reg.after[IW-1:0];
                        wb_data = bef_reg;
                    end
                    live_ctl.clr_en = 1'b1;
                    clr_idx         = cur_reg;
                end
                state_next = S_OUT;
            end

            S_APPEND:
            begin
                wa_en         = 1'b1;
                wa_data.after = LW'(spare_reg);
                heap_top_next = heap_top_reg + AW'(add_reg);
                state_next    = S_OUT;
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word register, loaded once the previous word has been taken.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_pay_next  = out_pay_reg;
        out_st_next   = out_st_reg;
        out_tot_next  = out_tot_reg;
        out_used_next = out_used_reg;
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tvalid_next = 1'b1;
            out_pay_next  = res_pay_reg;
            out_st_next   = res_st_reg;
            out_tot_next  = heap_top_reg;
            out_used_next = alloc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            heap_top_reg <= AW'(INIT_HEAP_BYTES);
            alloc_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cur_reg      <= '0;
            steps_reg    <= '0;
            op_reg       <= OP_ALLOC;
        end
        else
        begin
            state_reg    <= state_next;
            heap_top_reg <= heap_top_next;
            alloc_reg    <= alloc_next;
            m_tvalid_reg <= m_tvalid_next;
            cur_reg      <= cur_next;
            steps_reg    <= steps_next;
            op_reg       <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg     <= need_next;
        off_reg      <= off_next;
        add_reg      <= add_next;
        spare_reg    <= spare_next;
        ent_reg      <= ent_next;
        bef_reg      <= bef_next;
        res_pay_reg  <= res_pay_next;
        res_st_reg   <= res_st_next;
        out_pay_reg  <= out_pay_next;
        out_st_reg   <= out_st_next;
        out_tot_reg  <= out_tot_next;
        out_used_reg <= out_used_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 3 * AW - STW){1'b0}},
                       out_used_reg, out_tot_reg, out_st_reg, out_pay_reg};

    // A payload offset is only offered with an ok status.
    assign pay_on_fail = m_tvalid_reg && (out_pay_reg != '0) && (out_st_reg != ST_OK);

    `FFHA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "taken while busy")
    `FFHA_ASSERT_ALWAYS(a_used_in_heap, alloc_reg <= heap_top_reg, "used bytes exceed heap size")
    `FFHA_ASSERT_ALWAYS(a_payload_on_ok, !pay_on_fail, "payload offset with a failure status")

endmodule
